// ===== hw/rtl/latency_statistics_accumulator_macros.svh =====
// Assertion macros for the latency statistics accumulator checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef LATENCY_STATISTICS_ACCUMULATOR_MACROS_SVH
`define LATENCY_STATISTICS_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define LSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lsa_pkg.sv =====
// Shared constants, codes and command types of the latency statistics accumulator.
// No dependencies.
`timescale 1ns / 1ps

package lsa_pkg;

  localparam int LATENCY_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int KIND_W    = 2;
  localparam int IN_LAT_W  = 24;
  localparam int OUT_LAT_W = 24;
  localparam int OUT_CNT_W = 16;
  localparam int LOSS_W    = 7;
  localparam int PERCENT   = 100;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROBE  = 2'd0,
    KIND_REPLY  = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_LOSS,
    LD_MEAN,
    LD_A,
    LD_B,
    LD_VAR,
    LD_VAR2,
    LD_SQRT
  } load_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } step_e;

  typedef enum logic [1:0] {
    SV_NONE,
    SV_LOSS,
    SV_MEAN,
    SV_A
  } save_e;

  typedef struct packed {
    logic  upd;
    load_e load;
    step_e step;
    save_e save;
    logic  out_load;
  } cmd_t;

endpackage

// ===== hw/rtl/lsa_in_if.sv =====
// Event channel: valid/ready handshake carrying event kind and round-trip time.
// Depends on lsa_pkg.
`timescale 1ns / 1ps

interface lsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [lsa_pkg::KIND_W-1:0]    kind;
  logic [lsa_pkg::IN_LAT_W-1:0]  rtt_us;

  modport source (output valid, output kind, output rtt_us, input ready);
  modport sink   (input valid, input kind, input rtt_us, output ready);
endinterface

// ===== hw/rtl/lsa_out_if.sv =====
// Report channel: valid/ready handshake carrying one statistics report.
// Depends on lsa_pkg.
`timescale 1ns / 1ps

interface lsa_out_if;
  logic                           valid;
  logic                           ready;
  logic [lsa_pkg::OUT_CNT_W-1:0]  sent_total;
  logic [lsa_pkg::OUT_CNT_W-1:0]  received_total;
  logic [lsa_pkg::LOSS_W-1:0]     loss_percent;
  logic                           has_latency;
  logic [lsa_pkg::OUT_LAT_W-1:0]  latency_min;
  logic [lsa_pkg::OUT_LAT_W-1:0]  latency_mean;
  logic [lsa_pkg::OUT_LAT_W-1:0]  latency_max;
  logic [lsa_pkg::OUT_LAT_W-1:0]  latency_deviation;

  modport source (
    output valid, output sent_total, output received_total, output loss_percent,
    output has_latency, output latency_min, output latency_mean, output latency_max,
    output latency_deviation, input ready
  );
  modport sink (
    input valid, input sent_total, input received_total, input loss_percent,
    input has_latency, input latency_min, input latency_mean, input latency_max,
    input latency_deviation, output ready
  );
endinterface

// ===== hw/rtl/lsa_ctrl.sv =====
// Controller: handshake, report sequencing and iteration counting.
// Depends on lsa_pkg; drives the command struct of lsa_datapath.
`timescale 1ns / 1ps

module lsa_ctrl #(
  parameter int LATENCY_BITS = lsa_pkg::LATENCY_BITS_DEF,
  parameter int COUNT_BITS   = lsa_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [lsa_pkg::KIND_W-1:0] kind_i,
  output logic                       in_ready_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output lsa_pkg::cmd_t              cmd_o
);

  localparam int SUM_W  = LATENCY_BITS + COUNT_BITS;
  localparam int WORK_W = 2 * SUM_W;
  localparam int ITER_W = $clog2(WORK_W + 1);

  localparam logic [ITER_W-1:0] N_DIV  = ITER_W'(WORK_W);
  localparam logic [ITER_W-1:0] N_MULA = ITER_W'(COUNT_BITS);
  localparam logic [ITER_W-1:0] N_MULB = ITER_W'(SUM_W);
  localparam logic [ITER_W-1:0] N_ROOT = ITER_W'(LATENCY_BITS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOSS = 4'd1;
  localparam logic [3:0] S_MEAN = 4'd2;
  localparam logic [3:0] S_MULA = 4'd3;
  localparam logic [3:0] S_MULB = 4'd4;
  localparam logic [3:0] S_VAR1 = 4'd5;
  localparam logic [3:0] S_VAR2 = 4'd6;
  localparam logic [3:0] S_ROOT = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              work;
  logic [ITER_W-1:0] iter_n;
  logic [3:0]        next_s;
  lsa_pkg::load_e    ld_sel;
  lsa_pkg::step_e    op_sel;
  lsa_pkg::save_e    sv_sel;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    work        = 1'b0;
    iter_n      = N_DIV;
    next_s      = S_IDLE;
    ld_sel      = lsa_pkg::LD_NONE;
    op_sel      = lsa_pkg::OP_NONE;
    sv_sel      = lsa_pkg::SV_NONE;
    cmd_o       = '{upd: 1'b0, load: lsa_pkg::LD_NONE, step: lsa_pkg::OP_NONE,
                    save: lsa_pkg::SV_NONE, out_load: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        cmd_o.upd = accept;
        if (accept && (kind_i == lsa_pkg::KIND_REPORT)) begin
          state_d = S_LOSS;
          cnt_d   = '0;
        end
      end
      S_LOSS: begin
        work = 1'b1; iter_n = N_DIV; next_s = S_MEAN;
        ld_sel = lsa_pkg::LD_LOSS; op_sel = lsa_pkg::OP_DIV;
      end
      S_MEAN: begin
        work = 1'b1; iter_n = N_DIV; next_s = S_MULA;
        ld_sel = lsa_pkg::LD_MEAN; op_sel = lsa_pkg::OP_DIV; sv_sel = lsa_pkg::SV_LOSS;
      end
      S_MULA: begin
        work = 1'b1; iter_n = N_MULA; next_s = S_MULB;
        ld_sel = lsa_pkg::LD_A; op_sel = lsa_pkg::OP_MUL; sv_sel = lsa_pkg::SV_MEAN;
      end
      S_MULB: begin
        work = 1'b1; iter_n = N_MULB; next_s = S_VAR1;
        ld_sel = lsa_pkg::LD_B; op_sel = lsa_pkg::OP_MUL; sv_sel = lsa_pkg::SV_A;
      end
      S_VAR1: begin
        work = 1'b1; iter_n = N_DIV; next_s = S_VAR2;
        ld_sel = lsa_pkg::LD_VAR; op_sel = lsa_pkg::OP_DIV;
      end
      S_VAR2: begin
        work = 1'b1; iter_n = N_DIV; next_s = S_ROOT;
        ld_sel = lsa_pkg::LD_VAR2; op_sel = lsa_pkg::OP_DIV;
      end
      S_ROOT: begin
        work = 1'b1; iter_n = N_ROOT; next_s = S_DONE;
        ld_sel = lsa_pkg::LD_SQRT; op_sel = lsa_pkg::OP_SQRT;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (work) begin
      if (cnt_q == '0) begin
        cmd_o.load = ld_sel;
        cmd_o.save = sv_sel;
      end else begin
        cmd_o.step = op_sel;
      end
      if (cnt_q == iter_n) begin
        state_d = next_s;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/lsa_datapath.sv =====
// Datapath: running accumulators, shared shift-add / shift-subtract / root unit,
// and the report register. Depends on lsa_pkg; driven by lsa_ctrl commands.
`timescale 1ns / 1ps

module lsa_datapath #(
  parameter int LATENCY_BITS = lsa_pkg::LATENCY_BITS_DEF,
  parameter int COUNT_BITS   = lsa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsa_pkg::cmd_t                 cmd_i,
  input  logic [lsa_pkg::KIND_W-1:0]    kind_i,
  input  logic [lsa_pkg::IN_LAT_W-1:0]  rtt_us_i,
  output logic [lsa_pkg::OUT_CNT_W-1:0] sent_total_o,
  output logic [lsa_pkg::OUT_CNT_W-1:0] received_total_o,
  output logic [lsa_pkg::LOSS_W-1:0]    loss_percent_o,
  output logic                          has_latency_o,
  output logic [lsa_pkg::OUT_LAT_W-1:0] latency_min_o,
  output logic [lsa_pkg::OUT_LAT_W-1:0] latency_mean_o,
  output logic [lsa_pkg::OUT_LAT_W-1:0] latency_max_o,
  output logic [lsa_pkg::OUT_LAT_W-1:0] latency_deviation_o
);

  localparam int LAT    = LATENCY_BITS;
  localparam int CNT    = COUNT_BITS;
  localparam int SUM_W  = LAT + CNT;
  localparam int SQ_W   = 2 * LAT + CNT;
  localparam int WORK_W = 2 * SUM_W;
  localparam int DV_W   = CNT + 1;
  localparam int LN_W   = CNT + 8;
  localparam int LOSS_W = lsa_pkg::LOSS_W;
  localparam int OLW    = lsa_pkg::OUT_LAT_W;
  localparam int OCW    = lsa_pkg::OUT_CNT_W;
  localparam logic [CNT-1:0] CNT_MAX = {CNT{1'b1}};

  // running state
  logic [CNT-1:0]   sent_q, recv_q;
  logic [LAT-1:0]   min_q, max_q;
  logic [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]  sq_q;

  // shared arithmetic unit
  logic [WORK_W-1:0] acc_q, opa_q, opb_q, a_q;
  logic [DV_W-1:0]   drem_q;
  logic [LAT+1:0]    srem_q;
  logic [LAT-1:0]    root_q;
  logic [LOSS_W-1:0] loss_q;
  logic [LAT-1:0]    mean_q;

  logic [LAT-1:0]    rtt;
  logic [2*LAT-1:0]  rtt_sq;
  logic              loss_en;
  logic [CNT-1:0]    loss_diff;
  logic [LN_W-1:0]   loss_num;
  logic [DV_W-1:0]   loss_div;
  logic [CNT-1:0]    div_r;
  logic [WORK_W-1:0] var_diff;
  logic [DV_W:0]     dv_sh, dv_sub;
  logic              dv_ge;
  logic [LAT+3:0]    sq_sh, sq_trial, sq_sub;
  logic              sq_ge;

  assign rtt    = rtt_us_i[LAT-1:0];
  assign rtt_sq = (2*LAT)'(rtt) * (2*LAT)'(rtt);

  assign loss_en   = (sent_q != '0) && (recv_q < sent_q);
  assign loss_diff = sent_q - recv_q;
  assign loss_num  = LN_W'(loss_diff) * LN_W'(2 * lsa_pkg::PERCENT) + LN_W'(sent_q);
  assign loss_div  = loss_en ? {sent_q, 1'b0} : DV_W'(1);
  assign div_r     = (recv_q == '0) ? CNT'(1) : recv_q;
  assign var_diff  = (a_q >= acc_q) ? (a_q - acc_q) : '0;

  assign dv_sh  = {drem_q, opa_q[WORK_W-1]};
  assign dv_ge  = dv_sh >= {1'b0, opb_q[DV_W-1:0]};
  assign dv_sub = dv_sh - {1'b0, opb_q[DV_W-1:0]};

  assign sq_sh    = {srem_q, opa_q[2*LAT-1 -: 2]};
  assign sq_trial = (LAT+4)'({root_q, 2'b01});
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_sub   = sq_sh - sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
      recv_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
    end else if (cmd_i.upd) begin
      unique case (kind_i)
        lsa_pkg::KIND_PROBE: begin
          if (sent_q != CNT_MAX) sent_q <= sent_q + 1'b1;
        end
        lsa_pkg::KIND_REPLY: begin
          if (recv_q != CNT_MAX) begin
            if ((recv_q == '0) || (rtt < min_q)) min_q <= rtt;
            if (rtt > max_q) max_q <= rtt;
            recv_q <= recv_q + 1'b1;
            sum_q  <= sum_q + SUM_W'(rtt);
            sq_q   <= sq_q + SQ_W'(rtt_sq);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.load)
      lsa_pkg::LD_LOSS: begin
        opa_q  <= loss_en ? WORK_W'(loss_num) : '0;
        opb_q  <= WORK_W'(loss_div);
        drem_q <= '0;
      end
      lsa_pkg::LD_MEAN: begin
        opa_q  <= WORK_W'(sum_q);
        opb_q  <= WORK_W'(div_r);
        drem_q <= '0;
      end
      lsa_pkg::LD_A: begin
        acc_q <= '0;
        opa_q <= WORK_W'(sq_q);
        opb_q <= WORK_W'(recv_q);
      end
      lsa_pkg::LD_B: begin
        acc_q <= '0;
        opa_q <= WORK_W'(sum_q);
        opb_q <= WORK_W'(sum_q);
      end
      lsa_pkg::LD_VAR: begin
        opa_q  <= var_diff;
        opb_q  <= WORK_W'(div_r);
        drem_q <= '0;
      end
      lsa_pkg::LD_VAR2: drem_q <= '0;
      lsa_pkg::LD_SQRT: begin
        srem_q <= '0;
        root_q <= '0;
      end
      default: ;
    endcase

    unique case (cmd_i.step)
      lsa_pkg::OP_MUL: begin
        if (opb_q[0]) acc_q <= acc_q + opa_q;
        opa_q <= {opa_q[WORK_W-2:0], 1'b0};
        opb_q <= {1'b0, opb_q[WORK_W-1:1]};
      end
      lsa_pkg::OP_DIV: begin
        drem_q <= dv_ge ? dv_sub[DV_W-1:0] : dv_sh[DV_W-1:0];
        opa_q  <= {opa_q[WORK_W-2:0], dv_ge};
      end
      lsa_pkg::OP_SQRT: begin
        srem_q <= sq_ge ? sq_sub[LAT+1:0] : sq_sh[LAT+1:0];
        root_q <= {root_q[LAT-2:0], sq_ge};
        opa_q  <= {opa_q[WORK_W-3:0], 2'b00};
      end
      default: ;
    endcase

    unique case (cmd_i.save)
      lsa_pkg::SV_LOSS: loss_q <= opa_q[LOSS_W-1:0];
      lsa_pkg::SV_MEAN: mean_q <= opa_q[LAT-1:0];
      lsa_pkg::SV_A:    a_q    <= acc_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sent_total_o        <= OCW'(sent_q);
      received_total_o    <= OCW'(recv_q);
      loss_percent_o      <= loss_q;
      has_latency_o       <= (recv_q != '0);
      latency_min_o       <= OLW'(min_q);
      latency_mean_o      <= OLW'(mean_q);
      latency_max_o       <= OLW'(max_q);
      latency_deviation_o <= OLW'(root_q);
    end
  end

endmodule

// ===== hw/rtl/latency_statistics_accumulator.sv =====
// Latency statistics accumulator: probe/reply counting, min/max/mean/deviation.
// Top level; depends on lsa_pkg, lsa_in_if, lsa_out_if, lsa_ctrl, lsa_datapath.
//
// Probe and reply events are taken one per cycle, back to back, and fold into
// saturating counts, min, max, sum and sum of squares. A report request stops
// intake while one shared shift-add / shift-subtract unit works out the loss
// percent, floor mean, the variance (two divides by the reply count) and an
// integer square root, one bit per cycle; a new report also waits while the
// previous report is still held on the output.
// The report register lets new events in while a report is still unread.
`timescale 1ns / 1ps

module latency_statistics_accumulator #(
  parameter int LATENCY_BITS = lsa_pkg::LATENCY_BITS_DEF,
  parameter int COUNT_BITS   = lsa_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsa_in_if.sink    in_i,
  lsa_out_if.source out_o
);

  lsa_pkg::cmd_t cmd;
  logic          in_ready;
  logic          out_valid;

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  lsa_ctrl #(
    .LATENCY_BITS (LATENCY_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .kind_i      (in_i.kind),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  lsa_datapath #(
    .LATENCY_BITS (LATENCY_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .kind_i              (in_i.kind),
    .rtt_us_i            (in_i.rtt_us),
    .sent_total_o        (out_o.sent_total),
    .received_total_o    (out_o.received_total),
    .loss_percent_o      (out_o.loss_percent),
    .has_latency_o       (out_o.has_latency),
    .latency_min_o       (out_o.latency_min),
    .latency_mean_o      (out_o.latency_mean),
    .latency_max_o       (out_o.latency_max),
    .latency_deviation_o (out_o.latency_deviation)
  );

endmodule

// ===== hw/rtl/lsa_checker.sv =====
// Port-level checker for latency_statistics_accumulator, bound to the top level.
// Depends on lsa_pkg and latency_statistics_accumulator_macros.svh.
`timescale 1ns / 1ps
`include "latency_statistics_accumulator_macros.svh"

module lsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [lsa_pkg::KIND_W-1:0]    in_kind_i,
  input logic                          out_valid_i,
  input logic [lsa_pkg::OUT_CNT_W-1:0] sent_total_i,
  input logic [lsa_pkg::OUT_CNT_W-1:0] received_total_i,
  input logic [lsa_pkg::LOSS_W-1:0]    loss_percent_i,
  input logic                          has_latency_i,
  input logic [lsa_pkg::OUT_LAT_W-1:0] latency_min_i,
  input logic [lsa_pkg::OUT_LAT_W-1:0] latency_mean_i,
  input logic [lsa_pkg::OUT_LAT_W-1:0] latency_max_i
);

  `LSA_ASSERT_NXT(a_report_stalls_intake, in_valid_i && in_ready_i && (in_kind_i == lsa_pkg::KIND_REPORT), !in_ready_i, "report transfer did not stop intake")

  `LSA_ASSERT_IMP(a_report_from_busy, $rose(out_valid_i), !$past(in_ready_i), "report appeared without a busy cycle")

  `LSA_ASSERT_IMP(a_no_loss, out_valid_i && (received_total_i >= sent_total_i), loss_percent_i == '0, "nonzero loss with all probes answered")

  `LSA_ASSERT_IMP(a_order, out_valid_i && has_latency_i, (latency_min_i <= latency_mean_i) && (latency_mean_i <= latency_max_i), "mean outside min and max")

endmodule

bind latency_statistics_accumulator lsa_checker u_lsa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_kind_i        (in_i.kind),
  .out_valid_i      (out_o.valid),
  .sent_total_i     (out_o.sent_total),
  .received_total_i (out_o.received_total),
  .loss_percent_i   (out_o.loss_percent),
  .has_latency_i    (out_o.has_latency),
  .latency_min_i    (out_o.latency_min),
  .latency_mean_i   (out_o.latency_mean),
  .latency_max_i    (out_o.latency_max)
);

// ===== dv/tb_latency_statistics_accumulator.sv =====
// Self-checking testbench for latency_statistics_accumulator: event driver, report monitor.
// Predicts every report from its own copy of the counters and latency accumulators.
// Depends on lsa_pkg, lsa_in_if, lsa_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_latency_statistics_accumulator;

  localparam logic [lsa_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [lsa_pkg::IN_LAT_W-1:0] RTT_MAX = '1;
  localparam logic [lsa_pkg::OUT_CNT_W-1:0] COUNT_FULL = '1;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int DRAIN_CYCLES = 500;

  typedef struct packed {
    logic [lsa_pkg::KIND_W-1:0]   kind;
    logic [lsa_pkg::IN_LAT_W-1:0] rtt;
  } event_t;

  typedef struct packed {
    logic [lsa_pkg::OUT_CNT_W-1:0] sent;
    logic [lsa_pkg::OUT_CNT_W-1:0] received;
    logic [lsa_pkg::LOSS_W-1:0]    loss;
    logic                          has_lat;
    logic [lsa_pkg::OUT_LAT_W-1:0] lat_min;
    logic [lsa_pkg::OUT_LAT_W-1:0] lat_mean;
    logic [lsa_pkg::OUT_LAT_W-1:0] lat_max;
    logic [lsa_pkg::OUT_LAT_W-1:0] lat_dev;
  } report_t;

  logic clk_i;
  logic rst_ni;

  lsa_in_if  in_if ();
  lsa_out_if out_if ();

  latency_statistics_accumulator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  event_t  pending_events[$];
  report_t reports_due[$];

  logic [lsa_pkg::OUT_CNT_W-1:0] probe_count;
  logic [lsa_pkg::OUT_CNT_W-1:0] reply_count;
  logic [lsa_pkg::IN_LAT_W-1:0]  rtt_lowest;
  logic [lsa_pkg::IN_LAT_W-1:0]  rtt_highest;
  logic [39:0]                   rtt_sum;
  logic [63:0]                   rtt_sq_sum;

  int  idle_pct;
  int  stall_pct;
  int  rx_hold_left;
  bit  event_taken;
  int  events_accepted;
  int  reports_checked;
  int  mismatches;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] isqrt_floor(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe_bit;
    root = '0;
    probe_bit = 64'h1 << 62;
    while (probe_bit > v) probe_bit >>= 2;
    while (probe_bit != 0) begin
      if (v >= root + probe_bit) begin
        v -= root + probe_bit;
        root = (root >> 1) + probe_bit;
      end else begin
        root >>= 1;
      end
      probe_bit >>= 2;
    end
    return root;
  endfunction

  function automatic void apply_event(event_t ev);
    report_t     rep;
    logic [127:0] n_sq_sum;
    logic [127:0] sum_sq;
    logic [127:0] quotient;
    if (ev.kind == lsa_pkg::KIND_PROBE) begin
      if (probe_count != COUNT_FULL) probe_count++;
    end else if (ev.kind == lsa_pkg::KIND_REPLY) begin
      if (reply_count != COUNT_FULL) begin
        if (reply_count == 0 || ev.rtt < rtt_lowest) rtt_lowest = ev.rtt;
        if (ev.rtt > rtt_highest) rtt_highest = ev.rtt;
        reply_count++;
        rtt_sum += 40'(ev.rtt);
        rtt_sq_sum += 64'(ev.rtt) * 64'(ev.rtt);
      end
    end else if (ev.kind == lsa_pkg::KIND_REPORT) begin
      rep = '0;
      rep.sent = probe_count;
      rep.received = reply_count;
      if (probe_count != 0 && reply_count < probe_count) begin
        rep.loss = lsa_pkg::LOSS_W'((lsa_pkg::PERCENT * 2
                                     * (int'(probe_count) - int'(reply_count))
                                     + int'(probe_count)) / (2 * int'(probe_count)));
      end
      if (reply_count != 0) begin
        rep.has_lat = 1'b1;
        rep.lat_min = rtt_lowest;
        rep.lat_max = rtt_highest;
        rep.lat_mean = lsa_pkg::OUT_LAT_W'(rtt_sum / 40'(reply_count));
        n_sq_sum = 128'(reply_count) * 128'(rtt_sq_sum);
        sum_sq = 128'(rtt_sum) * 128'(rtt_sum);
        if (n_sq_sum >= sum_sq) begin
          quotient = (n_sq_sum - sum_sq) / (128'(reply_count) * 128'(reply_count));
          rep.lat_dev = lsa_pkg::OUT_LAT_W'(isqrt_floor(quotient[63:0]));
        end
      end
      reports_due.push_back(rep);
    end
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [lsa_pkg::IN_LAT_W-1:0] pick_rtt();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return lsa_pkg::IN_LAT_W'($urandom);
    if (sel < 50) return lsa_pkg::IN_LAT_W'($urandom_range(1000));
    if (sel < 75) return lsa_pkg::IN_LAT_W'($urandom_range(30000, 20000));
    if (sel < 85) return ($urandom_range(1) != 0) ? RTT_MAX : '0;
    return lsa_pkg::IN_LAT_W'($urandom_range(65535));
  endfunction

  function automatic void push_event(logic [lsa_pkg::KIND_W-1:0] kind,
                                     logic [lsa_pkg::IN_LAT_W-1:0] rtt);
    event_t ev;
    ev.kind = kind;
    ev.rtt = rtt;
    pending_events.push_back(ev);
  endfunction

  function automatic void push_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) push_event(lsa_pkg::KIND_PROBE, lsa_pkg::IN_LAT_W'($urandom));
      else if (sel < 80) push_event(lsa_pkg::KIND_REPLY, pick_rtt());
      else if (sel < 92) push_event(lsa_pkg::KIND_REPORT, lsa_pkg::IN_LAT_W'($urandom));
      else push_event(KIND_UNUSED, lsa_pkg::IN_LAT_W'($urandom));
    end
  endfunction

  task automatic settle();
    while (pending_events.size() != 0 || in_if.valid || reports_due.size() != 0
           || rx_hold_left != 0) begin
      @(posedge clk_i);
    end
  endtask

  // transfer sampling and prediction
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      event_t ev;
      ev.kind = in_if.kind;
      ev.rtt = in_if.rtt_us;
      apply_event(ev);
      events_accepted++;
      event_taken = 1'b1;
    end
  end

  // driver
  always @(negedge clk_i) begin
    event_t ev;
    if (!in_if.valid || event_taken) begin
      event_taken = 1'b0;
      if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
        ev = pending_events.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind <= ev.kind;
        in_if.rtt_us <= ev.rtt;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (reports_due.size() == 0) begin
        $error("report transfer with no report expected");
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        compare_field("sent_total", 64'(want.sent), 64'(out_if.sent_total));
        compare_field("received_total", 64'(want.received), 64'(out_if.received_total));
        compare_field("loss_percent", 64'(want.loss), 64'(out_if.loss_percent));
        compare_field("has_latency", 64'(want.has_lat), 64'(out_if.has_latency));
        compare_field("latency_min", 64'(want.lat_min), 64'(out_if.latency_min));
        compare_field("latency_mean", 64'(want.lat_mean), 64'(out_if.latency_mean));
        compare_field("latency_max", 64'(want.lat_max), 64'(out_if.latency_max));
        compare_field("latency_deviation", 64'(want.lat_dev),
                      64'(out_if.latency_deviation));
        reports_checked++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = lsa_pkg::KIND_PROBE;
    in_if.rtt_us = '0;
    out_if.ready = 1'b0;
    probe_count = '0;
    reply_count = '0;
    rtt_lowest = '0;
    rtt_highest = '0;
    rtt_sum = '0;
    rtt_sq_sum = '0;
    idle_pct = 0;
    stall_pct = 0;
    rx_hold_left = 0;
    event_taken = 1'b0;
    events_accepted = 0;
    reports_checked = 0;
    mismatches = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty report, replies ahead of probes, extremes and ignored kind
    push_event(lsa_pkg::KIND_REPORT, '0);
    push_event(lsa_pkg::KIND_REPLY, RTT_MAX);
    push_event(lsa_pkg::KIND_REPLY, '0);
    push_event(lsa_pkg::KIND_REPORT, RTT_MAX);
    push_event(KIND_UNUSED, RTT_MAX);
    push_event(KIND_UNUSED, '0);
    for (int i = 0; i < 4; i++) push_event(lsa_pkg::KIND_PROBE, RTT_MAX);
    push_event(lsa_pkg::KIND_REPORT, '0);
    push_event(lsa_pkg::KIND_REPLY, 24'd1);
    push_event(lsa_pkg::KIND_REPLY, 24'h555555);
    push_event(lsa_pkg::KIND_REPLY, 24'hAAAAAA);
    push_event(lsa_pkg::KIND_PROBE, '0);
    push_event(lsa_pkg::KIND_PROBE, '0);
    push_event(lsa_pkg::KIND_PROBE, '0);
    push_event(lsa_pkg::KIND_REPORT, '0);
    push_event(lsa_pkg::KIND_PROBE, '0);
    push_event(lsa_pkg::KIND_REPORT, '0);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      push_random(RANDOM_PER_PHASE);
      settle();
    end

    // hold the output long enough to back up the event input
    idle_pct = 0;
    stall_pct = 0;
    @(negedge clk_i);
    rx_hold_left = 3000;
    for (int i = 0; i < 3; i++) begin
      push_event(lsa_pkg::KIND_PROBE, '0);
      push_event(lsa_pkg::KIND_REPLY, pick_rtt());
      push_event(lsa_pkg::KIND_REPORT, '0);
      push_event(lsa_pkg::KIND_PROBE, '0);
      push_event(lsa_pkg::KIND_REPLY, pick_rtt());
    end
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d events transferred, %0d reports checked; covered idle and stall mixes,",
             events_accepted, reports_checked);
    $display("empty and extreme-latency reports, and a long output hold with input backpressure.");
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
